// ===== hdl/thpc_pkg.sv =====
package thpc_pkg;
  localparam int RingDepth = 16;
  localparam int SlotW = 4;
  localparam int FillW = 5;
  localparam int CoordW = 24;
  localparam int SpreadW = 24;
  localparam int EntryW = 4 * CoordW;
  localparam int SumW = CoordW + SlotW + 1;
  localparam int DistW = 2 * CoordW + 2;
  localparam int AccW = DistW + SlotW + 1;
  localparam int QuoW = AccW;
  localparam logic [SpreadW-1:0] SpreadOnes = '1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PICK, ST_SUM, ST_MEAN, ST_VAR, ST_DIVV, ST_SQRT, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
    logic [QuoW-1:0] num;
    logic [FillW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [QuoW-1:0] res;
  } div_rsp_t;
endpackage

// ===== hdl/thpc_ram.sv =====
module thpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/thpc_iter.sv =====
module thpc_iter import thpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [QuoW-1:0] rem_r, rem_nxt, quo_r, quo_nxt, bit_r, bit_nxt, num_r, num_nxt;
  logic [FillW-1:0] den_r, den_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic mode_r, mode_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [QuoW:0] trial;
  logic [QuoW-1:0] rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt; quo_r <= quo_nxt; bit_r <= bit_nxt; num_r <= num_nxt;
    den_r <= den_nxt; cnt_r <= cnt_nxt; mode_r <= mode_nxt;
  end

  always_comb begin
    rem_nxt = rem_r; quo_nxt = quo_r; bit_nxt = bit_r; num_nxt = num_r;
    den_nxt = den_r; cnt_nxt = cnt_r; mode_nxt = mode_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    rem_sh = {rem_r[QuoW-2:0], num_r[QuoW-1]};
    trial = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      mode_nxt = req.sqrt_mode;
      den_nxt = req.den;
      num_nxt = req.num;
      rem_nxt = req.sqrt_mode ? req.num : '0;
      quo_nxt = '0;
      bit_nxt = {1'b1, {(QuoW-1){1'b0}}};
      cnt_nxt = req.sqrt_mode ? 7'((QuoW + 1) / 2) : 7'(QuoW);
    end else if (busy_r) begin
      if (mode_r) begin
        trial = {1'b0, rem_r} - {1'b0, quo_r | bit_r};
        if (!trial[QuoW]) begin
          rem_nxt = trial[QuoW-1:0];
          quo_nxt = (quo_r >> 1) | bit_r;
        end else begin
          quo_nxt = quo_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end else begin
        trial = {1'b0, rem_sh} - {{(QuoW+1-FillW){1'b0}}, den_r};
        num_nxt = num_r << 1;
        if (!trial[QuoW]) begin
          rem_nxt = trial[QuoW-1:0];
          quo_nxt = {quo_r[QuoW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[QuoW-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res = quo_r;
endmodule

// ===== hdl/two_heap_position_clustering.sv =====
// Two-heap position clustering.
// Input: pulse start while busy is low with two candidate points (signed
// Q15.8). The transfer happens on that edge; busy rises the next cycle.
// Output: one result per item, shown for one cycle with out_valid. The
// receiver cannot stall, so the result is simply dropped if not taken.
// The first item after reset writes its entry and goes straight to the
// result. A later item runs one sum walk over the filled entries of both
// rings (fill counted after its write), four mean divisions on the shared
// iterative unit, then per heap a variance walk, a variance division and a
// square root. The result shows in the same cycle in which busy falls,
// and a new item can be taken in that same cycle.
// The rings sit in one RAM of 16 entries, 96 bits wide, one read port.
// Reset clears fill count, slot, centroids and best; ring contents are
// left as they are and only written entries are ever read.
module two_heap_position_clustering import thpc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [CoordW-1:0]  in_first_px,
  input  logic signed [CoordW-1:0]  in_first_py,
  input  logic signed [CoordW-1:0]  in_second_px,
  input  logic signed [CoordW-1:0]  in_second_py,
  output logic                      out_valid,
  output logic signed [CoordW-1:0]  out_pos_x,
  output logic signed [CoordW-1:0]  out_pos_y,
  output logic [SpreadW-1:0]        out_pos_spread,
  output logic signed [CoordW-1:0]  out_best_x,
  output logic signed [CoordW-1:0]  out_best_y,
  output logic [SpreadW-1:0]        out_best_spread,
  output logic [FillW-1:0]          out_heap_fill
);
  state_t st_r, st_nxt;
  logic [SlotW-1:0] slot_r, slot_nxt, idx_r, idx_nxt;
  logic [FillW-1:0] fill_r, fill_nxt, cnt_r, cnt_nxt;
  logic signed [CoordW-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [CoordW-1:0] lcx_r, lcx_nxt, lcy_r, lcy_nxt, rcx_r, rcx_nxt, rcy_r, rcy_nxt;
  logic signed [CoordW-1:0] bpx_r, bpx_nxt, bpy_r, bpy_nxt;
  logic [SpreadW-1:0] bsp_r, bsp_nxt, ls_r, ls_nxt;
  logic signed [SumW-1:0] slx_r, slx_nxt, sly_r, sly_nxt, srx_r, srx_nxt, sry_r, sry_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic side_r, side_nxt, pend_r, pend_nxt, pend2_r, ov_r, ov_nxt, dstart_r, dstart_nxt;
  logic signed [CoordW-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [SpreadW-1:0] osp_r, osp_nxt;

  logic we;
  logic [SlotW-1:0] waddr;
  logic [EntryW-1:0] wdata, rdata;
  div_req_t dreq;
  div_rsp_t drsp;
  logic accept;

  logic signed [CoordW-1:0] e_lx, e_ly, e_rx, e_ry, e_x, e_y, cx, cy;
  logic signed [CoordW:0] dx, dy;
  logic [DistW-1:0] dd, d0, d1, d2, d3;
  logic swap;
  logic signed [SumW-1:0] msum;
  logic [SumW-1:0] mabs;
  logic [QuoW-1:0] mq;
  logic signed [CoordW-1:0] mres;
  logic [SpreadW-1:0] sres;

  thpc_ram #(.Width(EntryW), .Depth(RingDepth)) u_ring (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(idx_r), .rdata(rdata)
  );

  thpc_iter u_iter (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic [DistW-1:0] pt_dist(input logic signed [CoordW-1:0] a,
      input logic signed [CoordW-1:0] b, input logic signed [CoordW-1:0] c,
      input logic signed [CoordW-1:0] d);
    logic signed [CoordW:0] u, v;
    logic [CoordW:0] au, av;
    u = {a[CoordW-1], a} - {c[CoordW-1], c};
    v = {b[CoordW-1], b} - {d[CoordW-1], d};
    au = u[CoordW] ? -u : u;
    av = v[CoordW] ? -v : v;
    return DistW'(au * au) + DistW'(av * av);
  endfunction

  assign accept = start && !busy;
  assign busy = (st_r != ST_IDLE);
  assign {e_lx, e_ly, e_rx, e_ry} = rdata;
  assign e_x = side_r ? e_rx : e_lx;
  assign e_y = side_r ? e_ry : e_ly;
  assign cx = side_r ? rcx_r : lcx_r;
  assign cy = side_r ? rcy_r : lcy_r;
  assign dx = {e_x[CoordW-1], e_x} - {cx[CoordW-1], cx};
  assign dy = {e_y[CoordW-1], e_y} - {cy[CoordW-1], cy};
  assign dd = DistW'($unsigned(dx[CoordW] ? -dx : dx) * $unsigned(dx[CoordW] ? -dx : dx))
            + DistW'($unsigned(dy[CoordW] ? -dy : dy) * $unsigned(dy[CoordW] ? -dy : dy));
  assign d0 = pt_dist(ax_r, ay_r, lcx_r, lcy_r);
  assign d1 = pt_dist(ax_r, ay_r, rcx_r, rcy_r);
  assign d2 = pt_dist(bx_r, by_r, lcx_r, lcy_r);
  assign d3 = pt_dist(bx_r, by_r, rcx_r, rcy_r);

  always_comb begin
    logic [DistW-1:0] m;
    logic [1:0] s;
    m = d0; s = 2'd0;
    if (d1 < m) begin m = d1; s = 2'd1; end
    if (d2 < m) begin m = d2; s = 2'd2; end
    if (d3 < m) begin m = d3; s = 2'd3; end
    swap = (s == 2'd1) || (s == 2'd2);
  end

  always_comb begin
    unique case (sub_r)
      2'd0: msum = slx_r;
      2'd1: msum = sly_r;
      2'd2: msum = srx_r;
      default: msum = sry_r;
    endcase
    mabs = msum[SumW-1] ? SumW'(-msum) : SumW'(msum);
    mq = drsp.res;
    mres = msum[SumW-1] ? CoordW'(-mq) : CoordW'(mq);
    sres = (mq > QuoW'(SpreadOnes)) ? SpreadOnes : mq[SpreadW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      slot_r <= '0; fill_r <= '0;
      lcx_r <= '0; lcy_r <= '0; rcx_r <= '0; rcy_r <= '0;
      bpx_r <= '0; bpy_r <= '0; bsp_r <= SpreadOnes;
      ov_r <= 1'b0; dstart_r <= 1'b0;
      pend_r <= 1'b0; pend2_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      slot_r <= slot_nxt; fill_r <= fill_nxt;
      lcx_r <= lcx_nxt; lcy_r <= lcy_nxt; rcx_r <= rcx_nxt; rcy_r <= rcy_nxt;
      bpx_r <= bpx_nxt; bpy_r <= bpy_nxt; bsp_r <= bsp_nxt;
      ov_r <= ov_nxt; dstart_r <= dstart_nxt;
      pend_r <= pend_nxt; pend2_r <= pend_r;
    end
    if (accept) begin
      ax_r <= in_first_px; ay_r <= in_first_py;
      bx_r <= in_second_px; by_r <= in_second_py;
    end
    idx_r <= idx_nxt; cnt_r <= cnt_nxt; sub_r <= sub_nxt; side_r <= side_nxt;
    acc_r <= acc_nxt;
    slx_r <= slx_nxt; sly_r <= sly_nxt; srx_r <= srx_nxt; sry_r <= sry_nxt;
    ls_r <= ls_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt; osp_r <= osp_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    slot_nxt = slot_r; fill_nxt = fill_r;
    lcx_nxt = lcx_r; lcy_nxt = lcy_r; rcx_nxt = rcx_r; rcy_nxt = rcy_r;
    bpx_nxt = bpx_r; bpy_nxt = bpy_r; bsp_nxt = bsp_r;
    idx_nxt = idx_r; cnt_nxt = cnt_r; sub_nxt = sub_r; side_nxt = side_r;
    pend_nxt = pend_r; acc_nxt = acc_r;
    slx_nxt = slx_r; sly_nxt = sly_r; srx_nxt = srx_r; sry_nxt = sry_r;
    ls_nxt = ls_r;
    ox_nxt = ox_r; oy_nxt = oy_r; osp_nxt = osp_r;
    ov_nxt = 1'b0; dstart_nxt = 1'b0;
    we = 1'b0; waddr = slot_r; wdata = {ax_r, ay_r, bx_r, by_r};
    dreq.start = dstart_r; dreq.sqrt_mode = 1'b0; dreq.num = '0;
    dreq.den = fill_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) st_nxt = ST_PICK;
      end
      ST_PICK: begin
        we = 1'b1;
        if (fill_r == '0) begin
          waddr = '0;
          slot_nxt = SlotW'(1 % RingDepth);
          fill_nxt = FillW'(1);
          lcx_nxt = ax_r; lcy_nxt = ay_r; rcx_nxt = bx_r; rcy_nxt = by_r;
          bpx_nxt = '0; bpy_nxt = '0; bsp_nxt = SpreadOnes;
          ox_nxt = '0; oy_nxt = '0; osp_nxt = SpreadOnes;
          st_nxt = ST_OUT;
        end else begin
          if (swap) wdata = {bx_r, by_r, ax_r, ay_r};
          slot_nxt = slot_r + SlotW'(1);
          if (fill_r != FillW'(RingDepth)) fill_nxt = fill_r + FillW'(1);
          idx_nxt = '0; cnt_nxt = '0; pend_nxt = 1'b0;
          slx_nxt = '0; sly_nxt = '0; srx_nxt = '0; sry_nxt = '0;
          st_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (pend2_r) begin
          slx_nxt = slx_r + SumW'(e_lx); sly_nxt = sly_r + SumW'(e_ly);
          srx_nxt = srx_r + SumW'(e_rx); sry_nxt = sry_r + SumW'(e_ry);
        end
        if (cnt_r == fill_r) begin
          pend_nxt = 1'b0;
          if (!pend_r && !pend2_r) begin
            sub_nxt = 2'd0; dstart_nxt = 1'b1; st_nxt = ST_MEAN;
          end
        end else begin
          idx_nxt = cnt_r[SlotW-1:0]; cnt_nxt = cnt_r + FillW'(1); pend_nxt = 1'b1;
        end
      end
      ST_MEAN: begin
        dreq.num = QuoW'(mabs) + QuoW'(fill_r >> 1);
        if (drsp.done) begin
          unique case (sub_r)
            2'd0: lcx_nxt = mres;
            2'd1: lcy_nxt = mres;
            2'd2: rcx_nxt = mres;
            default: rcy_nxt = mres;
          endcase
          sub_nxt = sub_r + 2'd1;
          if (sub_r == 2'd3) begin
            side_nxt = 1'b0; idx_nxt = '0; cnt_nxt = '0; pend_nxt = 1'b0;
            acc_nxt = '0; st_nxt = ST_VAR;
          end else begin
            dstart_nxt = 1'b1;
          end
        end
      end
      ST_VAR: begin
        if (pend2_r) acc_nxt = acc_r + AccW'(dd);
        if (cnt_r == fill_r) begin
          pend_nxt = 1'b0;
          if (!pend_r && !pend2_r) begin dstart_nxt = 1'b1; st_nxt = ST_DIVV; end
        end else begin
          idx_nxt = cnt_r[SlotW-1:0]; cnt_nxt = cnt_r + FillW'(1); pend_nxt = 1'b1;
        end
      end
      ST_DIVV: begin
        dreq.num = acc_r;
        if (drsp.done) begin
          acc_nxt = drsp.res; dstart_nxt = 1'b1; st_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        dreq.sqrt_mode = 1'b1;
        dreq.num = acc_r;
        if (drsp.done) begin
          if (!side_r) begin
            ls_nxt = sres;
            side_nxt = 1'b1; idx_nxt = '0; cnt_nxt = '0; pend_nxt = 1'b0;
            acc_nxt = '0; st_nxt = ST_VAR;
          end else begin
            if (ls_r < sres) begin
              ox_nxt = lcx_r; oy_nxt = lcy_r; osp_nxt = ls_r;
            end else begin
              ox_nxt = rcx_r; oy_nxt = rcy_r; osp_nxt = sres;
            end
            st_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (osp_r < bsp_r) begin
          bsp_nxt = osp_r; bpx_nxt = ox_r; bpy_nxt = oy_r;
        end
        ov_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_pos_x = ox_r;
  assign out_pos_y = oy_r;
  assign out_pos_spread = osp_r;
  assign out_best_x = bpx_r;
  assign out_best_y = bpy_r;
  assign out_best_spread = bsp_r;
  assign out_heap_fill = fill_r;
endmodule

// ===== hdl/thpc_checker.sv =====
module thpc_checker import thpc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic [SpreadW-1:0] out_pos_spread,
  input logic [SpreadW-1:0] out_best_spread,
  input logic [FillW-1:0] out_heap_fill
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after transfer");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_best_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_spread <= out_pos_spread || out_best_spread == SpreadOnes)
    else $error("best above current");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heap_fill != '0 && out_heap_fill <= FillW'(RingDepth))
    else $error("fill out of range");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than a cycle");
endmodule

bind two_heap_position_clustering thpc_checker u_thpc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_pos_spread(out_pos_spread), .out_best_spread(out_best_spread),
  .out_heap_fill(out_heap_fill)
);
